/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define NTRW_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define NTRW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/ntrw_pkg.sv */
// ----------------------------------------------------------------------------
// Neighbour table package
// Field widths, action codes and shared types of the neighbour table.
// ----------------------------------------------------------------------------
package ntrw_pkg;

    localparam int ADDR_W       = 56;
    localparam int LVL_W        = 8;
    localparam int TS_W         = 32;
    localparam int SLOT_W       = 4;
    localparam int ACT_W        = 3;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] neighbour_addr;
        logic [LVL_W-1:0]  signal_level;
        logic [TS_W-1:0]   timestamp;
        logic [SLOT_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [ADDR_W-1:0]    read_addr;
        logic [LVL_W-1:0]     read_level;
        logic [TS_W-1:0]      read_time;
    } out_item_t;

    typedef struct packed {
        logic              addr_en;
        logic              lt_en;
        logic [ADDR_W-1:0] addr;
        logic [LVL_W-1:0]  level;
        logic [TS_W-1:0]   tstamp;
    } store_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LVL_W-1:0]  level;
        logic [TS_W-1:0]   tstamp;
    } store_rd_t;

endpackage

/* rtl/ntrw_in_if.sv */
// ----------------------------------------------------------------------------
// Neighbour table input channel
// Valid/ready channel carrying report and read transactions.
// ----------------------------------------------------------------------------
interface ntrw_in_if;
    import ntrw_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] neighbour_addr;
    logic [LVL_W-1:0]  signal_level;
    logic [TS_W-1:0]   timestamp;
    logic [SLOT_W-1:0] slot_index;

    modport source (
        output valid, kind, neighbour_addr, signal_level, timestamp, slot_index,
        input  ready
    );

    modport sink (
        input  valid, kind, neighbour_addr, signal_level, timestamp, slot_index,
        output ready
    );
endinterface

/* rtl/ntrw_out_if.sv */
// ----------------------------------------------------------------------------
// Neighbour table result channel
// Valid/ready channel carrying one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface ntrw_out_if;
    import ntrw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [ADDR_W-1:0]    read_addr;
    logic [LVL_W-1:0]     read_level;
    logic [TS_W-1:0]      read_time;

    modport source (
        output valid, action, slot, entry_count, read_addr, read_level, read_time,
        input  ready
    );

    modport sink (
        input  valid, action, slot, entry_count, read_addr, read_level, read_time,
        output ready
    );
endinterface

/* rtl/ntrw_store.sv */
// ----------------------------------------------------------------------------
// Neighbour table entry store
// Address, level and timestamp memories with one write and one registered read.
// ----------------------------------------------------------------------------
module ntrw_store #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4
) (
    input  logic                clk,
    input  ntrw_pkg::store_wr_t wr,
    input  logic [IDX_W-1:0]    wr_idx,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output ntrw_pkg::store_rd_t rd_data
);
    import ntrw_pkg::*;

    logic [ADDR_W-1:0] addr_mem [CAPACITY];
    logic [LVL_W-1:0]  level_mem [CAPACITY];
    logic [TS_W-1:0]   time_mem [CAPACITY];
    store_rd_t         rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.addr_en)
        begin
            addr_mem[wr_idx] <= wr.addr;
        end
        if (wr.lt_en)
        begin
            level_mem[wr_idx] <= wr.level;
            time_mem[wr_idx]  <= wr.tstamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg.addr   <= addr_mem[rd_idx];
            rd_reg.level  <= level_mem[rd_idx];
            rd_reg.tstamp <= time_mem[rd_idx];
        end
    end

    assign rd_data = rd_reg;

endmodule

/* rtl/ntrw_seq.sv */
// ----------------------------------------------------------------------------
// Neighbour table sequencer
// Scans the store one slot per cycle through a shared address and level
// comparator, then refreshes, appends, replaces or drops the report; also serves slot reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntrw_seq #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ntrw_pkg::in_item_t  in_item,
    output ntrw_pkg::store_wr_t wr,
    output logic [IDX_W-1:0]    wr_idx,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_idx,
    input  ntrw_pkg::store_rd_t rd_data,
    output logic                done_valid,
    input  logic                done_take,
    output ntrw_pkg::out_item_t done_item
);
    import ntrw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [LVL_W-1:0] worst_reg, worst_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic             rd_ok_reg, rd_ok_next;
    in_item_t         item_reg, item_next;
    out_item_t        res_reg, res_next;
    logic             hit;
    logic             weaker;

    assign hit    = chk_vld_reg && (rd_data.addr == item_reg.neighbour_addr);
    assign weaker = chk_vld_reg && (rd_data.level > worst_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        iss_next     = iss_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        worst_next   = worst_reg;
        pick_next    = pick_reg;
        rd_ok_next   = rd_ok_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        wr           = '0;
        wr_idx       = chk_idx_reg;
        rd_en        = 1'b0;
        rd_idx       = iss_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    if (in_item.kind == KIND_READ)
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = IDX_W'(in_item.slot_index);
                        rd_ok_next = 32'(in_item.slot_index) < 32'(cnt_reg);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        iss_next     = '0;
                        chk_vld_next = 1'b0;
                        worst_next   = '0;
                        pick_next    = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                res_next             = '0;
                res_next.entry_count = CNT_OUT_W'(cnt_reg);
                wr.addr              = item_reg.neighbour_addr;
                wr.level             = item_reg.signal_level;
                wr.tstamp            = item_reg.timestamp;
                if (hit)
                begin
                    wr.lt_en        = 1'b1;
                    wr_idx          = chk_idx_reg;
                    res_next.action = ACT_REFRESH;
                    res_next.slot   = SLOT_W'(chk_idx_reg);
                    chk_vld_next    = 1'b0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    if (weaker)
                    begin
                        worst_next = rd_data.level;
                        pick_next  = chk_idx_reg;
                    end
                    if (iss_reg < cnt_reg)
                    begin
                        rd_en        = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_idx_next = iss_reg[IDX_W-1:0];
                        iss_next     = iss_reg + 1'b1;
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        if (!chk_vld_reg)
                        begin
                            state_next = ST_DONE;
                            priority if (cnt_reg < CNT_W'(CAPACITY))
                            begin
                                wr.addr_en           = 1'b1;
                                wr.lt_en             = 1'b1;
                                wr_idx               = cnt_reg[IDX_W-1:0];
                                cnt_next             = cnt_reg + 1'b1;
                                res_next.action      = ACT_APPEND;
                                res_next.slot        = SLOT_W'(cnt_reg);
                                res_next.entry_count = CNT_OUT_W'(cnt_next);
                            end
                            else if (worst_reg > item_reg.signal_level)
                            begin
                                wr.addr_en      = 1'b1;
                                wr.lt_en        = 1'b1;
                                wr_idx          = pick_reg;
                                res_next.action = ACT_REPLACE;
                                res_next.slot   = SLOT_W'(pick_reg);
                            end
                            else
                            begin
                                res_next.action = ACT_DROP;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_next             = '0;
                res_next.action      = ACT_READ;
                res_next.slot        = item_reg.slot_index;
                res_next.entry_count = CNT_OUT_W'(cnt_reg);
                if (rd_ok_reg)
                begin
                    res_next.read_addr  = rd_data.addr;
                    res_next.read_level = rd_data.level;
                    res_next.read_time  = rd_data.tstamp;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            iss_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            iss_reg     <= iss_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        worst_reg   <= worst_next;
        pick_reg    <= pick_next;
        rd_ok_reg   <= rd_ok_next;
        item_reg    <= item_next;
        res_reg     <= res_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign done_valid = (state_reg == ST_DONE);
    assign done_item  = res_reg;

    `NTRW_ASSERT(a_cnt_bound, (cnt_reg <= CNT_W'(CAPACITY)), "Entry count exceeds capacity.")
    `NTRW_ASSERT_IMPL(a_cnt_step, (cnt_reg != $past(cnt_reg)), (cnt_reg == $past(cnt_reg) + 1'b1 && $past(state_reg) == ST_SCAN), "Entry count changed other than by an append.")
    `NTRW_ASSERT_IMPL(a_slot_range, (state_reg == ST_DONE && res_reg.action != ACT_READ && res_reg.action != ACT_DROP), (32'(res_reg.slot) < CAPACITY), "Report touched a slot beyond capacity.")
    `NTRW_ASSERT_IMPL(a_scan_bound, (state_reg == ST_SCAN), (iss_reg <= cnt_reg), "Scan pointer ran past the valid entries.")

endmodule

/* rtl/neighbour_table_replace_weakest_core.sv */
// ----------------------------------------------------------------------------
// Neighbour table with weakest-entry replacement
// Top level: sequencer, entry store and result output register.
// ----------------------------------------------------------------------------
// The item channel takes report and read transactions. A report looks up its
// address; a hit refreshes level and timestamp, a miss appends while the table
// has room, and a full table replaces the first entry with the greatest level
// if that level is greater than the reported one, otherwise the report is
// dropped. A read returns the contents of one slot, or zeros for an unused
// slot. Every item gives exactly one transaction on the result channel.
// A report that misses is checked against every valid entry, since the shared
// comparator checks one slot per cycle behind a registered memory read; a hit
// ends the scan at that slot, and a read passes through the registered memory
// read alone. The item channel is ready only while the sequencer is idle, one
// item at a time, so an item is not accepted before the last one is finished.
// Reset empties the table at once; no clearing pass is needed. When the
// receiver stalls, the finished result waits in the output register and the
// block can accept and work on one more item, holding its result until the
// output register is free.
// ----------------------------------------------------------------------------
module neighbour_table_replace_weakest_core #(
    parameter int CAPACITY = ntrw_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ntrw_in_if.sink    item,
    ntrw_out_if.source result
);
    import ntrw_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    in_item_t         in_item;
    store_wr_t        wr;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    store_rd_t        rd_data;
    logic             done_valid;
    logic             done_take;
    out_item_t        done_item;
    logic             out_vld_reg;
    out_item_t        out_item_reg;

    assign in_item.kind           = item.kind;
    assign in_item.neighbour_addr = item.neighbour_addr;
    assign in_item.signal_level   = item.signal_level;
    assign in_item.timestamp      = item.timestamp;
    assign in_item.slot_index     = item.slot_index;

    ntrw_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_ready   (item.ready),
        .in_item    (in_item),
        .wr         (wr),
        .wr_idx     (wr_idx),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .done_valid (done_valid),
        .done_take  (done_take),
        .done_item  (done_item)
    );

    ntrw_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .wr_idx  (wr_idx),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign done_take = done_valid && (!out_vld_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (done_take)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_take)
        begin
            out_item_reg <= done_item;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.action      = out_item_reg.action;
    assign result.slot        = out_item_reg.slot;
    assign result.entry_count = out_item_reg.entry_count;
    assign result.read_addr   = out_item_reg.read_addr;
    assign result.read_level  = out_item_reg.read_level;
    assign result.read_time   = out_item_reg.read_time;

endmodule
